// File: hw/rtl/fiaf_pkg.sv
// Shared types, constants and scoring functions for the fire and intrusion alarm fusion block.
`timescale 1ns / 1ps
`default_nettype none

package fiaf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLAME = 2'd0;
    localparam logic [1:0] CFG_SMOKE = 2'd1;
    localparam logic [1:0] CFG_CO    = 2'd2;
    localparam logic [1:0] CFG_TEMP  = 2'd3;

    // Threshold reset values
    localparam logic [11:0] FLAME_THR_RST = 12'd2000;
    localparam logic [7:0]  SMOKE_THR_RST = 8'd50;
    localparam logic [7:0]  CO_THR_RST    = 8'd50;
    localparam logic [7:0]  TEMP_THR_RST  = 8'd45;

    // Score points
    localparam logic [6:0] PTS_FLAME  = 7'd40;
    localparam logic [6:0] PTS_SMOKE  = 7'd30;
    localparam logic [6:0] PTS_CO     = 7'd20;
    localparam logic [6:0] PTS_TEMP   = 7'd10;
    localparam logic [6:0] PTS_PRES   = 7'd30;
    localparam logic [6:0] PTS_NEAR   = 7'd15;
    localparam logic [6:0] PTS_MOVE   = 7'd25;
    localparam logic [6:0] PTS_STILL  = 7'd50;
    localparam logic [15:0] NEAR_DIST = 16'd200;

    // Grade bounds
    localparam logic [6:0] GRADE1_MIN = 7'd30;
    localparam logic [6:0] GRADE2_MIN = 7'd60;

    // Grade and level codes
    localparam logic [1:0] GRADE_SAFE    = 2'd0;
    localparam logic [1:0] GRADE_SUSPECT = 2'd1;
    localparam logic [1:0] GRADE_CONFIRM = 2'd2;

    localparam logic [1:0] LVL_NONE    = 2'd0;
    localparam logic [1:0] LVL_WARNING = 2'd1;
    localparam logic [1:0] LVL_ALARM   = 2'd2;

    localparam logic KIND_FIRE      = 1'b0;
    localparam logic KIND_INTRUSION = 1'b1;

    // Warning confirmations needed to raise the alarm
    localparam logic [1:0] CONFIRM_COUNT = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified word handed from front to back
    typedef struct packed {
        logic       armed;
        logic [1:0] fire_grade;
        logic [1:0] intrusion_grade;
    } t_item;

    // Alarm mode, one-hot
    typedef enum logic [3:0] {
        MODE_DISARMED = 4'b0001,
        MODE_ARMED    = 4'b0010,
        MODE_WARNING  = 4'b0100,
        MODE_ALARM    = 4'b1000
    } t_mode;

    // Map a score to its grade
    function automatic logic [1:0] grade_of(input logic [6:0] score);
        logic [1:0] g;
        if (score < GRADE1_MIN) begin
            g = GRADE_SAFE;
        end else if (score < GRADE2_MIN) begin
            g = GRADE_SUSPECT;
        end else begin
            g = GRADE_CONFIRM;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fiaf_front.sv
// Front end: threshold registers and scoring of each sensor word into two grades.
`timescale 1ns / 1ps
`default_nettype none

module fiaf_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [11:0]        i_cfg_data,
    input  wire logic               i_armed_switch,
    input  wire logic [11:0]        i_flame_intensity,
    input  wire logic [15:0]        i_smoke_level,
    input  wire logic [15:0]        i_co_level,
    input  wire logic signed [7:0]  i_temperature,
    input  wire logic               i_pir_hit,
    input  wire logic               i_person_seen,
    input  wire logic [15:0]        i_target_distance,
    input  wire logic [7:0]         i_moving_energy,
    input  wire logic [7:0]         i_still_energy,
    output fiaf_pkg::t_item         o_item
);

    logic [11:0] r_flame_thr;
    logic [7:0]  r_smoke_thr;
    logic [7:0]  r_co_thr;
    logic [7:0]  r_temp_thr;

    logic [6:0]  fire_score;
    logic [6:0]  intr_score;
    logic        temp_hot;

    // Hold threshold registers, update on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flame_thr <= fiaf_pkg::FLAME_THR_RST;
            r_smoke_thr <= fiaf_pkg::SMOKE_THR_RST;
            r_co_thr    <= fiaf_pkg::CO_THR_RST;
            r_temp_thr  <= fiaf_pkg::TEMP_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fiaf_pkg::CFG_FLAME: r_flame_thr <= i_cfg_data;
                fiaf_pkg::CFG_SMOKE: r_smoke_thr <= i_cfg_data[7:0];
                fiaf_pkg::CFG_CO:    r_co_thr    <= i_cfg_data[7:0];
                fiaf_pkg::CFG_TEMP:  r_temp_thr  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Negative temperatures never exceed the unsigned threshold
    assign temp_hot = !i_temperature[7] && (i_temperature[6:0] > r_temp_thr[6:0]
                      || 1'b0) && !r_temp_thr[7];

    // Add up fire points; smoke and CO thresholds scale to Q12.4
    always_comb begin
        fire_score = '0;
        if (i_flame_intensity > r_flame_thr) fire_score = fire_score + fiaf_pkg::PTS_FLAME;
        if (i_smoke_level > {4'b0, r_smoke_thr, 4'b0}) fire_score = fire_score + fiaf_pkg::PTS_SMOKE;
        if (i_co_level > {4'b0, r_co_thr, 4'b0}) fire_score = fire_score + fiaf_pkg::PTS_CO;
        if (temp_hot) fire_score = fire_score + fiaf_pkg::PTS_TEMP;
    end

    // Add up intrusion points
    always_comb begin
        intr_score = '0;
        if (i_pir_hit || i_person_seen) intr_score = intr_score + fiaf_pkg::PTS_PRES;
        if (i_target_distance < fiaf_pkg::NEAR_DIST) intr_score = intr_score + fiaf_pkg::PTS_NEAR;
        if (i_moving_energy != 8'd0) intr_score = intr_score + fiaf_pkg::PTS_MOVE;
        if (i_still_energy != 8'd0) intr_score = intr_score + fiaf_pkg::PTS_STILL;
    end

    // Pack the classified word
    always_comb begin
        o_item.armed           = i_armed_switch;
        o_item.fire_grade      = fiaf_pkg::grade_of(fire_score);
        o_item.intrusion_grade = fiaf_pkg::grade_of(intr_score);
    end

endmodule

`default_nettype wire

// File: hw/rtl/fiaf_queue.sv
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module fiaf_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fiaf_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output fiaf_pkg::t_item      o_item
);

    fiaf_pkg::t_item                r_mem [fiaf_pkg::QUEUE_DEPTH];
    logic [fiaf_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [fiaf_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [fiaf_pkg::QCNT_W-1:0]    r_count;
    logic [fiaf_pkg::QCNT_W-1:0]    n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == fiaf_pkg::QCNT_W'(fiaf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fiaf_back.sv
// Back end: alarm mode machine with confirmation counter and the result register.
`timescale 1ns / 1ps
`default_nettype none

module fiaf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire fiaf_pkg::t_item i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [1:0]           o_alarm_level,
    output logic                 o_alarm_kind,
    output logic [1:0]           o_fire_grade,
    output logic [1:0]           o_intrusion_grade
);

    fiaf_pkg::t_mode r_mode;
    fiaf_pkg::t_mode n_mode;
    fiaf_pkg::t_mode arm_mode;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic [1:0]      count_up;
    logic [1:0]      count_dn;
    logic [1:0]      level;
    logic            hot;
    logic            r_out_valid;
    logic [1:0]      r_level;
    logic            r_kind;
    logic [1:0]      r_fire_grade;
    logic [1:0]      r_intr_grade;

    // Take a word when the result register is free or being drained
    assign o_q_pop = i_q_valid && (!r_out_valid || !i_stall);

    assign hot = (i_q_item.fire_grade != fiaf_pkg::GRADE_SAFE)
              || (i_q_item.intrusion_grade != fiaf_pkg::GRADE_SAFE);
    assign count_up = r_count + 2'd1;
    assign count_dn = r_count - 2'd1;

    // Apply the arm switch first
    always_comb begin
        if (!i_q_item.armed) begin
            arm_mode = fiaf_pkg::MODE_DISARMED;
        end else if (r_mode == fiaf_pkg::MODE_DISARMED) begin
            arm_mode = fiaf_pkg::MODE_ARMED;
        end else begin
            arm_mode = r_mode;
        end
    end

    // Advance the mode and count, pick the level
    always_comb begin
        n_mode  = arm_mode;
        n_count = r_count;
        level   = fiaf_pkg::LVL_NONE;
        case (arm_mode)
            fiaf_pkg::MODE_ARMED: begin
                if (hot) begin
                    n_mode  = fiaf_pkg::MODE_WARNING;
                    n_count = 2'd1;
                    level   = fiaf_pkg::LVL_WARNING;
                end
            end
            fiaf_pkg::MODE_WARNING: begin
                if (hot) begin
                    n_count = count_up;
                    if (count_up >= fiaf_pkg::CONFIRM_COUNT) begin
                        n_mode = fiaf_pkg::MODE_ALARM;
                        level  = fiaf_pkg::LVL_ALARM;
                    end else begin
                        level  = fiaf_pkg::LVL_WARNING;
                    end
                end else begin
                    n_count = count_dn;
                    if (count_dn == 2'd0) n_mode = fiaf_pkg::MODE_ARMED;
                end
            end
            fiaf_pkg::MODE_ALARM: level = fiaf_pkg::LVL_ALARM;
            default: level = fiaf_pkg::LVL_NONE;
        endcase
    end

    // Update state on each taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fiaf_pkg::MODE_DISARMED;
            r_count <= 2'd0;
        end else if (o_q_pop) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_level      <= level;
            r_kind       <= (i_q_item.fire_grade >= i_q_item.intrusion_grade)
                            ? fiaf_pkg::KIND_FIRE : fiaf_pkg::KIND_INTRUSION;
            r_fire_grade <= i_q_item.fire_grade;
            r_intr_grade <= i_q_item.intrusion_grade;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_alarm_level     = r_level;
    assign o_alarm_kind      = r_kind;
    assign o_fire_grade      = r_fire_grade;
    assign o_intrusion_grade = r_intr_grade;

endmodule

`default_nettype wire

// File: hw/rtl/fire_intrusion_alarm_fusion_core.sv
// Top level of the fire and intrusion alarm fusion block.
//
// Input channel: i_valid with o_stall; a sensor word is taken at a rising edge
// with i_valid high and o_stall low. The front scores it into a fire grade and
// an intrusion grade in the same cycle and pushes it into a two-entry queue.
// The back pops one word per cycle while its result register is free or
// being drained, runs the disarmed/armed/warning/alarm machine and loads a
// result register read on o_valid with i_stall. A taken word passes through
// the queue and then the result register before its result reaches the ports.
// Throughput: one word per cycle while the receiver does not stall, set by
// the combinational scoring and the pop of the mode machine.
// Configuration: i_cfg_we, i_cfg_idx and i_cfg_data write one threshold per
// edge; write only while the block holds no word in flight.
// Reset (i_rst_n low, synchronous) restores the thresholds, sets the mode to
// disarmed, clears the count and empties the queue and result register.
// A stalled receiver holds the result; the queue then fills and o_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module fire_intrusion_alarm_fusion_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [11:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_armed_switch,
    input  wire logic [11:0]        i_flame_intensity,
    input  wire logic [15:0]        i_smoke_level,
    input  wire logic [15:0]        i_co_level,
    input  wire logic signed [7:0]  i_temperature,
    input  wire logic               i_pir_hit,
    input  wire logic               i_person_seen,
    input  wire logic [15:0]        i_target_distance,
    input  wire logic [7:0]         i_moving_energy,
    input  wire logic [7:0]         i_still_energy,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_alarm_level,
    output logic                    o_alarm_kind,
    output logic [1:0]              o_fire_grade,
    output logic [1:0]              o_intrusion_grade
);

    fiaf_pkg::t_item front_item;
    fiaf_pkg::t_item q_item;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    assign o_stall = q_full;

    fiaf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_armed_switch    (i_armed_switch),
        .i_flame_intensity (i_flame_intensity),
        .i_smoke_level     (i_smoke_level),
        .i_co_level        (i_co_level),
        .i_temperature     (i_temperature),
        .i_pir_hit         (i_pir_hit),
        .i_person_seen     (i_person_seen),
        .i_target_distance (i_target_distance),
        .i_moving_energy   (i_moving_energy),
        .i_still_energy    (i_still_energy),
        .o_item            (front_item)
    );

    fiaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fiaf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_alarm_level     (o_alarm_level),
        .o_alarm_kind      (o_alarm_kind),
        .o_fire_grade      (o_fire_grade),
        .o_intrusion_grade (o_intrusion_grade)
    );

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the fire and intrusion alarm fusion core.
`timescale 1ns / 1ps

module testbench;

    import fiaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;
    localparam int SETTLE_CYCLES  = 3;

    // One sensor word as offered on the input channel
    typedef struct packed {
        logic              armed;
        logic [11:0]       flame;
        logic [15:0]       smoke;
        logic [15:0]       co;
        logic signed [7:0] temp;
        logic              pir;
        logic              person;
        logic [15:0]       distance;
        logic [7:0]        moving;
        logic [7:0]        still;
    } sensor_sample_t;

    // One verdict as returned on the output channel
    typedef struct packed {
        logic [1:0] level;
        logic       kind;
        logic [1:0] fire_grade;
        logic [1:0] intr_grade;
    } fusion_result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [11:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic               i_armed_switch;
    logic [11:0]        i_flame_intensity;
    logic [15:0]        i_smoke_level;
    logic [15:0]        i_co_level;
    logic signed [7:0]  i_temperature;
    logic               i_pir_hit;
    logic               i_person_seen;
    logic [15:0]        i_target_distance;
    logic [7:0]         i_moving_energy;
    logic [7:0]         i_still_energy;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_alarm_level;
    logic               o_alarm_kind;
    logic [1:0]         o_fire_grade;
    logic [1:0]         o_intrusion_grade;

    // Predictor copy of thresholds and alarm state
    logic [11:0] thr_flame;
    logic [7:0]  thr_smoke;
    logic [7:0]  thr_co;
    logic [7:0]  thr_temp;
    t_mode       arm_mode;
    logic [1:0]  confirm_tally;

    fusion_result_t pending_results[$];
    fusion_result_t want;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    logic hold_req     = 1'b0;
    int hold_left      = 0;

    int mismatches     = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int alarms_seen    = 0;
    int warnings_seen  = 0;
    int settings_used  = 0;

    fire_intrusion_alarm_fusion_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_armed_switch    (i_armed_switch),
        .i_flame_intensity (i_flame_intensity),
        .i_smoke_level     (i_smoke_level),
        .i_co_level        (i_co_level),
        .i_temperature     (i_temperature),
        .i_pir_hit         (i_pir_hit),
        .i_person_seen     (i_person_seen),
        .i_target_distance (i_target_distance),
        .i_moving_energy   (i_moving_energy),
        .i_still_energy    (i_still_energy),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_alarm_level     (o_alarm_level),
        .o_alarm_kind      (o_alarm_kind),
        .o_fire_grade      (o_fire_grade),
        .o_intrusion_grade (o_intrusion_grade)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Fire points under the current thresholds; all compares are strict
    function automatic int fire_points(input sensor_sample_t s);
        int pts;
        pts = 0;
        if (s.flame > thr_flame) pts += PTS_FLAME;
        // Q12.4 reading against a whole-ppm threshold
        if (s.smoke > {4'd0, thr_smoke, 4'd0}) pts += PTS_SMOKE;
        if (s.co > {4'd0, thr_co, 4'd0}) pts += PTS_CO;
        if ($signed(s.temp) > $signed({1'b0, thr_temp})) pts += PTS_TEMP;
        return pts;
    endfunction

    function automatic int intrusion_points(input sensor_sample_t s);
        int pts;
        pts = 0;
        if (s.pir || s.person) pts += PTS_PRES;
        if (s.distance < NEAR_DIST) pts += PTS_NEAR;
        if (s.moving != 8'd0) pts += PTS_MOVE;
        if (s.still != 8'd0) pts += PTS_STILL;
        return pts;
    endfunction

    function automatic logic [1:0] points_grade(input int pts);
        if (pts >= int'(GRADE2_MIN)) return GRADE_CONFIRM;
        if (pts >= int'(GRADE1_MIN)) return GRADE_SUSPECT;
        return GRADE_SAFE;
    endfunction

    // Grade one word and advance the alarm mode machine
    function automatic fusion_result_t fuse_sample(input sensor_sample_t s);
        fusion_result_t r;
        logic hot;
        r.fire_grade = points_grade(fire_points(s));
        r.intr_grade = points_grade(intrusion_points(s));
        r.kind = (r.fire_grade >= r.intr_grade) ? KIND_FIRE : KIND_INTRUSION;
        hot = (r.fire_grade != GRADE_SAFE) || (r.intr_grade != GRADE_SAFE);
        r.level = LVL_NONE;

        // Arm switch takes effect before the grades are looked at
        if (!s.armed) begin
            arm_mode = MODE_DISARMED;
        end else if (arm_mode == MODE_DISARMED) begin
            arm_mode = MODE_ARMED;
        end

        case (arm_mode)
            MODE_ARMED: begin
                if (hot) begin
                    arm_mode      = MODE_WARNING;
                    confirm_tally = 2'd1;
                    r.level       = LVL_WARNING;
                end
            end
            MODE_WARNING: begin
                if (hot) begin
                    confirm_tally = confirm_tally + 2'd1;
                    if (confirm_tally >= CONFIRM_COUNT) begin
                        arm_mode = MODE_ALARM;
                        r.level  = LVL_ALARM;
                    end else begin
                        r.level = LVL_WARNING;
                    end
                end else begin
                    confirm_tally = confirm_tally - 2'd1;
                    if (confirm_tally == 2'd0) arm_mode = MODE_ARMED;
                end
            end
            MODE_ALARM: begin
                r.level = LVL_ALARM;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic int near_value(input int center, input int lo, input int hi);
        int v;
        v = center + int'($urandom_range(4)) - 2;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic sensor_sample_t quiet_sample(input logic armed);
        sensor_sample_t s;
        s = '0;
        s.armed    = armed;
        s.distance = 16'hFFFF;
        return s;
    endfunction

    // Random word, retried until its hot/calm nature matches the request or 40 tries are spent
    function automatic sensor_sample_t random_sample(input logic want_hot);
        sensor_sample_t s;
        int tries;
        tries = 0;
        do begin
            s.armed = ($urandom_range(11) != 0);
            case ($urandom_range(3))
                0: s.flame = 12'($urandom_range(4095));
                1: s.flame = 12'(near_value(int'(thr_flame), 0, 4095));
                2: s.flame = 12'($urandom_range(thr_flame));
                default: s.flame = 12'hFFF;
            endcase
            case ($urandom_range(3))
                0: s.smoke = 16'($urandom_range(65535));
                1: s.smoke = 16'(near_value(int'(thr_smoke) * 16, 0, 65535));
                2: s.smoke = 16'($urandom_range({thr_smoke, 4'd0}));
                default: s.smoke = 16'hFFFF;
            endcase
            case ($urandom_range(3))
                0: s.co = 16'($urandom_range(65535));
                1: s.co = 16'(near_value(int'(thr_co) * 16, 0, 65535));
                2: s.co = 16'($urandom_range({thr_co, 4'd0}));
                default: s.co = 16'hFFFF;
            endcase
            case ($urandom_range(2))
                0: s.temp = 8'($urandom_range(255));
                1: s.temp = 8'(near_value(int'(thr_temp), -128, 127));
                default: s.temp = 8'(int'($urandom_range(40)) - 20);
            endcase
            s.pir    = ($urandom_range(3) == 0);
            s.person = ($urandom_range(3) == 0);
            case ($urandom_range(2))
                0: s.distance = 16'($urandom_range(65535));
                1: s.distance = 16'(near_value(int'(NEAR_DIST), 0, 65535));
                default: s.distance = 16'($urandom_range(255));
            endcase
            s.moving = ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : 8'd0;
            s.still  = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'd0;
            tries++;
        end while (((fire_points(s) >= int'(GRADE1_MIN)) ||
                    (intrusion_points(s) >= int'(GRADE1_MIN))) != want_hot && tries < 40);
        return s;
    endfunction

    // Offer one word, hold it until taken, and log its expected verdict
    task automatic send_sample(input sensor_sample_t s);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_armed_switch    <= s.armed;
        i_flame_intensity <= s.flame;
        i_smoke_level     <= s.smoke;
        i_co_level        <= s.co;
        i_temperature     <= s.temp;
        i_pir_hit         <= s.pir;
        i_person_seen     <= s.person;
        i_target_distance <= s.distance;
        i_moving_energy   <= s.moving;
        i_still_energy    <= s.still;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(fuse_sample(s));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_run(input int count);
        repeat (count) send_sample(random_sample($urandom_range(99) < 45));
        i_valid <= 1'b0;
    endtask

    // Wait until every verdict is back and the block has gone quiet
    task automatic settle_block();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_thresholds(input logic [11:0] flame, input logic [11:0] smoke,
                                    input logic [11:0] co, input logic [11:0] temp);
        settle_block();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FLAME;
        i_cfg_data <= flame;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SMOKE;
        i_cfg_data <= smoke;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_CO;
        i_cfg_data <= co;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TEMP;
        i_cfg_data <= temp;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_flame = flame;
        thr_smoke = smoke[7:0];
        thr_co    = co[7:0];
        thr_temp  = temp[7:0];
        settings_used++;
    endtask

    // Boundaries of the score terms, CO only just above its threshold, and a full walk of the mode machine
    task automatic test_directed_defaults();
        sensor_sample_t s;
        send_gap_pct   = 0;
        recv_stall_pct = 25;
        // Disarmed ignores even a fully hot word
        s = quiet_sample(1'b0);
        s.flame = 12'hFFF; s.smoke = 16'hFFFF; s.co = 16'hFFFF; s.temp = 8'sd127;
        s.pir = 1'b1; s.person = 1'b1; s.distance = 16'd0; s.moving = 8'hFF; s.still = 8'hFF;
        send_sample(s);
        send_sample(quiet_sample(1'b1));
        s = quiet_sample(1'b1); s.flame = 12'd2000; send_sample(s);
        s = quiet_sample(1'b1); s.flame = 12'd2001; send_sample(s);
        s = quiet_sample(1'b1); s.smoke = 16'd800;  send_sample(s);
        s = quiet_sample(1'b1); s.smoke = 16'd801;  send_sample(s);
        s = quiet_sample(1'b1); s.co = 16'd801;     send_sample(s);
        s = quiet_sample(1'b1); s.temp = 8'sd46;    send_sample(s);
        s = quiet_sample(1'b1); s.co = 16'd801; s.temp = 8'sd46; send_sample(s);
        // Negative temperature never exceeds the threshold
        s = quiet_sample(1'b1); s.co = 16'd801; s.temp = -8'sd128; send_sample(s);
        s = quiet_sample(1'b1); s.co = 16'd801; s.temp = 8'sd45; send_sample(s);
        s = quiet_sample(1'b1); s.pir = 1'b1;        send_sample(s);
        s = quiet_sample(1'b1); s.person = 1'b1;     send_sample(s);
        s = quiet_sample(1'b1); s.distance = 16'd199; send_sample(s);
        s = quiet_sample(1'b1); s.distance = 16'd200; s.moving = 8'd1; send_sample(s);
        s = quiet_sample(1'b1); s.still = 8'd1;      send_sample(s);
        s = quiet_sample(1'b1); s.pir = 1'b1; s.distance = 16'd0; s.moving = 8'd1;
        send_sample(s);
        // Third confirmation raises the alarm, which then holds
        s = quiet_sample(1'b1); s.flame = 12'd2001; s.smoke = 16'd801; send_sample(s);
        send_sample(quiet_sample(1'b1));
        send_sample(quiet_sample(1'b0));
        s = quiet_sample(1'b0); s.still = 8'hFF;     send_sample(s);
        // Re-arm: the count reloads on entry to warning
        s = quiet_sample(1'b1); s.flame = 12'hFFF;   send_sample(s);
        s = quiet_sample(1'b1); s.flame = 12'hFFF; s.still = 8'd1; s.pir = 1'b1;
        send_sample(s);
        repeat (3) send_sample(quiet_sample(1'b1));
        i_valid <= 1'b0;
    endtask

    // All thresholds at zero, then all at their top value
    task automatic test_threshold_extremes();
        send_gap_pct   = 10;
        recv_stall_pct = 30;
        write_thresholds(12'h000, 12'hF00, 12'hF00, 12'hF00);
        send_random_run(40);
        write_thresholds(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_random_run(40);
    endtask

    // Long random runs under three idle profiles, fresh thresholds each
    task automatic test_random_profiles();
        int gap_pct[3]   = '{6, 80, 0};
        int stall_pct[3] = '{80, 6, 0};
        for (int p = 0; p < 3; p++) begin
            write_thresholds(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                             12'($urandom_range(4095)), 12'($urandom_range(4095)));
            send_gap_pct   = gap_pct[p];
            recv_stall_pct = stall_pct[p];
            send_random_run(250);
        end
    endtask

    // Fill the block behind a held receiver, drain with the sender paused, then run again under random stalls
    task automatic test_backpressure();
        write_thresholds(12'(FLAME_THR_RST), 12'(SMOKE_THR_RST),
                         12'(CO_THR_RST), 12'(TEMP_THR_RST));
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        send_random_run(24);
        settle_block();
        recv_stall_pct = 50;
        send_random_run(16);
    endtask

    // Receiver: random stalls plus a long hold on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each taken verdict with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("verdict arrived with no sensor word pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_alarm_level !== want.level) begin
                    $error("alarm_level: expected %0d, got %0d", want.level, o_alarm_level);
                    mismatches++;
                end
                if (o_alarm_kind !== want.kind) begin
                    $error("alarm_kind: expected %0d, got %0d", want.kind, o_alarm_kind);
                    mismatches++;
                end
                if (o_fire_grade !== want.fire_grade) begin
                    $error("fire_grade: expected %0d, got %0d", want.fire_grade, o_fire_grade);
                    mismatches++;
                end
                if (o_intrusion_grade !== want.intr_grade) begin
                    $error("intrusion_grade: expected %0d, got %0d",
                           want.intr_grade, o_intrusion_grade);
                    mismatches++;
                end
                if (want.level == LVL_ALARM) alarms_seen++;
                if (want.level == LVL_WARNING) warnings_seen++;
            end
            results_seen++;
        end
    end

    // Abort when no word moves on either channel for too long
    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_FLAME;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_armed_switch    = 1'b0;
        i_flame_intensity = '0;
        i_smoke_level     = '0;
        i_co_level        = '0;
        i_temperature     = '0;
        i_pir_hit         = 1'b0;
        i_person_seen     = 1'b0;
        i_target_distance = '0;
        i_moving_energy   = '0;
        i_still_energy    = '0;
        thr_flame         = FLAME_THR_RST;
        thr_smoke         = SMOKE_THR_RST;
        thr_co            = CO_THR_RST;
        thr_temp          = TEMP_THR_RST;
        arm_mode          = MODE_DISARMED;
        confirm_tally     = 2'd0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_defaults();
        test_threshold_extremes();
        test_random_profiles();
        test_backpressure();
        settle_block();

        $display("Coverage: %0d sensor words checked over %0d threshold settings",
                 results_seen, settings_used + 1);
        $display("Verdicts: %0d alarm, %0d warning; mismatches: %0d",
                 alarms_seen, warnings_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/fiaf_pkg.sv
hw/rtl/fiaf_front.sv
hw/rtl/fiaf_queue.sv
hw/rtl/fiaf_back.sv
hw/rtl/fire_intrusion_alarm_fusion_core.sv
test/testbench.sv
